/* design/idea_pkg.sv */
// Shared types, constants and mod-65537 multiply helpers for the IDEA cipher pipeline.
package idea_pkg;

  localparam int WORD_W         = 16;
  localparam int IDX_W          = 6;
  localparam int KEYS_PER_ROUND = 6;
  localparam int OUT_KEYS       = 4;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [WORD_W:0]     mop_t;
  typedef logic [2*WORD_W:0]   prod_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_BLOCK = 1'b1
  } func_t;

  // Sideband that travels with every beat.
  typedef struct packed {
    logic             valid;
    logic             load;
    logic [IDX_W-1:0] idx;
    word_t            kval;
  } ctl_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } blk_t;

  // Word 0 stands for 2^16.
  function automatic mop_t mul_op(word_t x);
    return (x == '0) ? {1'b1, {WORD_W{1'b0}}} : {1'b0, x};
  endfunction

  function automatic prod_t mul_prod(word_t x, word_t y);
    return prod_t'(mul_op(x)) * prod_t'(mul_op(y));
  endfunction

  // lo - hi mod 65537; adding 65537 is +1 in the low 16 bits.
  function automatic word_t mul_red(prod_t p);
    logic [WORD_W+1:0] diff;
    diff = {2'b00, p[WORD_W-1:0]} - {1'b0, p[2*WORD_W:WORD_W]};
    return diff[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, diff[WORD_W+1]};
  endfunction

endpackage

/* design/idea_round.sv */
// One IDEA round as six register stages, holding its own six subkeys.
module idea_round import idea_pkg::*; #(
  parameter int RND = 1
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  blk_t  blk_i,
  output ctl_t  ctl_o,
  output blk_t  blk_o
);

  localparam int BASE = KEYS_PER_ROUND * (RND - 1);

  word_t key_r [KEYS_PER_ROUND];

  ctl_t  c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  prod_t p1_r, p4_r, pm_r, ps_r;
  word_t s1_a2_r, s1_a3_r;
  word_t s2_x1_r, s2_a2_r, s2_a3_r, s2_x4_r, s2_t_r, s2_v_r;
  word_t s3_x1_r, s3_a2_r, s3_a3_r, s3_x4_r, s3_v_r;
  word_t s4_m_r, s4_e_r, s4_x1_r, s4_a2_r, s4_a3_r, s4_x4_r;
  word_t s5_m_r, s5_x1_r, s5_a2_r, s5_a3_r, s5_x4_r;
  blk_t  s6_blk_r;

  word_t x1, x4, m_val, s_val, u_val;

  // Each key is written at the edge where a load passes the stage that uses it.
  always_ff @(posedge clk) begin
    if (en && ctl_i.valid && ctl_i.load) begin
      for (int j = 0; j < OUT_KEYS; j++) begin
        if (ctl_i.idx == IDX_W'(BASE + j)) begin
          key_r[j] <= ctl_i.kval;
        end
      end
    end
    if (en && c2_r.valid && c2_r.load && c2_r.idx == IDX_W'(BASE + 4)) begin
      key_r[4] <= c2_r.kval;
    end
    if (en && c4_r.valid && c4_r.load && c4_r.idx == IDX_W'(BASE + 5)) begin
      key_r[5] <= c4_r.kval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
      c5_r.valid <= 1'b0;
      c6_r.valid <= 1'b0;
    end else if (en) begin
      c1_r <= ctl_i;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
      c5_r <= c4_r;
      c6_r <= c5_r;
    end
  end

  always_comb begin
    x1    = mul_red(p1_r);
    x4    = mul_red(p4_r);
    m_val = mul_red(pm_r);
    s_val = mul_red(ps_r);
    u_val = s5_m_r + s_val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= mul_prod(blk_i.a, key_r[0]);
      p4_r    <= mul_prod(blk_i.d, key_r[3]);
      s1_a2_r <= blk_i.b + key_r[1];
      s1_a3_r <= blk_i.c + key_r[2];

      s2_x1_r <= x1;
      s2_x4_r <= x4;
      s2_a2_r <= s1_a2_r;
      s2_a3_r <= s1_a3_r;
      s2_t_r  <= x1 ^ s1_a3_r;
      s2_v_r  <= s1_a2_r ^ x4;

      pm_r    <= mul_prod(key_r[4], s2_t_r);
      s3_x1_r <= s2_x1_r;
      s3_a2_r <= s2_a2_r;
      s3_a3_r <= s2_a3_r;
      s3_x4_r <= s2_x4_r;
      s3_v_r  <= s2_v_r;

      s4_m_r  <= m_val;
      s4_e_r  <= m_val + s3_v_r;
      s4_x1_r <= s3_x1_r;
      s4_a2_r <= s3_a2_r;
      s4_a3_r <= s3_a3_r;
      s4_x4_r <= s3_x4_r;

      ps_r    <= mul_prod(key_r[5], s4_e_r);
      s5_m_r  <= s4_m_r;
      s5_x1_r <= s4_x1_r;
      s5_a2_r <= s4_a2_r;
      s5_a3_r <= s4_a3_r;
      s5_x4_r <= s4_x4_r;

      s6_blk_r.a <= s5_x1_r ^ s_val;
      s6_blk_r.b <= s5_a3_r ^ s_val;
      s6_blk_r.c <= s5_a2_r ^ u_val;
      s6_blk_r.d <= s5_x4_r ^ u_val;
    end
  end

  assign ctl_o = c6_r;
  assign blk_o = s6_blk_r;

endmodule

/* design/idea_out_xform.sv */
// IDEA output transform as two register stages, holding the last four subkeys.
module idea_out_xform import idea_pkg::*; #(
  parameter int ROUNDS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  blk_t  blk_i,
  output logic  res_valid,
  output blk_t  res_blk
);

  localparam int BASE = KEYS_PER_ROUND * ROUNDS;

  word_t key_r [OUT_KEYS];
  logic  v1_r, v2_r;
  prod_t p1_r, p4_r;
  word_t o2_r, o3_r;
  blk_t  res_r;

  always_ff @(posedge clk) begin
    if (en && ctl_i.valid && ctl_i.load) begin
      for (int j = 0; j < OUT_KEYS; j++) begin
        if (ctl_i.idx == IDX_W'(BASE + j)) begin
          key_r[j] <= ctl_i.kval;
        end
      end
    end
  end

  // Load beats stop here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= ctl_i.valid && !ctl_i.load;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= mul_prod(blk_i.a, key_r[0]);
      p4_r    <= mul_prod(blk_i.d, key_r[3]);
      o2_r    <= blk_i.c + key_r[1];
      o3_r    <= blk_i.b + key_r[2];
      res_r.a <= mul_red(p1_r);
      res_r.b <= o2_r;
      res_r.c <= o3_r;
      res_r.d <= mul_red(p4_r);
    end
  end

  assign res_valid = v2_r;
  assign res_blk   = res_r;

endmodule

/* design/idea_block_cipher.sv */
// IDEA block cipher: top level with round pipeline, output transform and output skid.
//
//  channel | ports                                             | dir | handshake
//  --------+---------------------------------------------------+-----+----------------------
//  in      | in_func, in_subkey_index, in_subkey_value,        | in  | in_valid / in_stall
//          | in_word_in_a..d                                   |     |
//  out     | out_word_out_a..d                                 | out | out_valid / out_stall
//
//  One beat enters per cycle while in_stall is low; a block result shows on out_valid
//  once its beat has passed every round, the output transform and the output register.
//  Each round chains three mod-65537 multiplies, each split into a multiply stage and
//  a reduce stage. Subkey loads run down the same pipe and update each key where it is
//  used, so loads and blocks keep their order. Loads give no result.
//  Reset (rst_n low, synchronous) clears the valid bits, out_valid and the skid's full flag; the
//  subkeys are undefined until loaded. A one-entry skid behind the output register
//  absorbs one result under out_stall; in_stall is that skid's full flag.
module idea_block_cipher import idea_pkg::*; #(
  parameter int ROUNDS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [IDX_W-1:0]    in_subkey_index,
  input  logic [WORD_W-1:0]   in_subkey_value,
  input  logic [WORD_W-1:0]   in_word_in_a,
  input  logic [WORD_W-1:0]   in_word_in_b,
  input  logic [WORD_W-1:0]   in_word_in_c,
  input  logic [WORD_W-1:0]   in_word_in_d,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_word_out_a,
  output logic [WORD_W-1:0]   out_word_out_b,
  output logic [WORD_W-1:0]   out_word_out_c,
  output logic [WORD_W-1:0]   out_word_out_d
);

  ctl_t ctl_c [ROUNDS+1];
  blk_t blk_c [ROUNDS+1];

  logic en;
  logic res_valid;
  blk_t res_blk;
  logic take;

  logic out_valid_r, out_valid_nxt;
  blk_t out_blk_r, out_blk_nxt;
  logic skid_full_r, skid_full_nxt;
  blk_t skid_blk_r, skid_blk_nxt;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  assign ctl_c[0] = '{valid: in_valid,
                      load:  (func_t'(in_func) == FUNC_LOAD),
                      idx:   in_subkey_index,
                      kval:  in_subkey_value};
  assign blk_c[0] = '{a: in_word_in_a,
                      b: in_word_in_b,
                      c: in_word_in_c,
                      d: in_word_in_d};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    idea_round #(
      .RND (g + 1)
    ) u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_c[g]),
      .blk_i (blk_c[g]),
      .ctl_o (ctl_c[g+1]),
      .blk_o (blk_c[g+1])
    );
  end

  idea_out_xform #(
    .ROUNDS (ROUNDS)
  ) u_out_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_i     (ctl_c[ROUNDS]),
    .blk_i     (blk_c[ROUNDS]),
    .res_valid (res_valid),
    .res_blk   (res_blk)
  );

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_blk_nxt   = out_blk_r;
    skid_full_nxt = skid_full_r;
    skid_blk_nxt  = skid_blk_r;
    if (take) begin
      if (skid_full_r) begin
        out_blk_nxt   = skid_blk_r;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (en && res_valid) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_blk_nxt   = res_blk;
      end else begin
        skid_full_nxt = 1'b1;
        skid_blk_nxt  = res_blk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_blk_r  <= out_blk_nxt;
    skid_blk_r <= skid_blk_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_word_out_a = out_blk_r.a;
  assign out_word_out_b = out_blk_r.b;
  assign out_word_out_c = out_blk_r.c;
  assign out_word_out_d = out_blk_r.d;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall && res_valid))
    else $error("skid filled without a stalled output beat");

  a_skid_drains_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |=> out_valid_r)
    else $error("output register emptied while skid was full");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |=> $stable(res_valid))
    else $error("pipeline moved while skid was full");

endmodule

/* test/idea_block_cipher_checker.sv */
// Checker for idea_block_cipher: tracks subkey loads, predicts each block and compares results.
`timescale 1ns / 1ps
module idea_block_cipher_checker import idea_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_func,
  input  logic [IDX_W-1:0] in_subkey_index,
  input  word_t            in_subkey_value,
  input  word_t            in_word_in_a,
  input  word_t            in_word_in_b,
  input  word_t            in_word_in_c,
  input  word_t            in_word_in_d,
  input  logic             out_valid,
  input  logic             out_stall,
  input  word_t            out_word_out_a,
  input  word_t            out_word_out_b,
  input  word_t            out_word_out_c,
  input  word_t            out_word_out_d,
  output int               mismatches,
  output int               blocks_due,
  output int               blocks_seen
);

  localparam int ROUNDS    = 8;
  localparam int KEY_COUNT = KEYS_PER_ROUND * ROUNDS + OUT_KEYS;

  word_t key_mem [KEY_COUNT];
  blk_t  expected_blocks [$];
  blk_t  got_blk;
  blk_t  want_blk;
  int    err_cnt;
  int    seen_cnt;

  // 0 stands for 2^16; a product of 2^16 folds back to 0 on truncation.
  function automatic word_t mul_mod(word_t x, word_t y);
    longint unsigned xv;
    longint unsigned yv;
    longint unsigned r;
    xv = (x == '0) ? 64'd65536 : 64'(x);
    yv = (y == '0) ? 64'd65536 : 64'(y);
    r  = (xv * yv) % 64'd65537;
    return word_t'(r);
  endfunction

  function automatic blk_t encipher(blk_t v);
    word_t w1, w2, w3, w4, m, s, u, t;
    blk_t  r;
    int    base;
    w1 = v.a;
    w2 = v.b;
    w3 = v.c;
    w4 = v.d;
    for (int rd = 0; rd < ROUNDS; rd++) begin
      base = rd * KEYS_PER_ROUND;
      w1 = mul_mod(w1, key_mem[base]);
      w4 = mul_mod(w4, key_mem[base+3]);
      w2 = w2 + key_mem[base+1];
      w3 = w3 + key_mem[base+2];
      m  = mul_mod(key_mem[base+4], w1 ^ w3);
      t  = m + (w2 ^ w4);
      s  = mul_mod(key_mem[base+5], t);
      u  = m + s;
      w1 = w1 ^ s;
      w4 = w4 ^ u;
      t  = w2 ^ u;
      w2 = w3 ^ s;
      w3 = t;
    end
    base = ROUNDS * KEYS_PER_ROUND;
    r.a = mul_mod(w1, key_mem[base]);
    r.b = w3 + key_mem[base+1];
    r.c = w2 + key_mem[base+2];
    r.d = mul_mod(w4, key_mem[base+3]);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_blk = '{out_word_out_a, out_word_out_b, out_word_out_c, out_word_out_d};
        if (expected_blocks.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got_blk);
        end else begin
          want_blk = expected_blocks.pop_front();
          seen_cnt++;
          for (int f = 0; f < 4; f++) begin
            if (got_blk[63-16*f -: 16] !== want_blk[63-16*f -: 16]) begin
              err_cnt++;
              $display("%0t: word_out %0d expected %h actual %h", $time, f,
                       want_blk[63-16*f -: 16], got_blk[63-16*f -: 16]);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_LOAD) begin
          if (in_subkey_index < KEY_COUNT) key_mem[in_subkey_index] = in_subkey_value;
        end else begin
          expected_blocks.push_back(encipher('{in_word_in_a, in_word_in_b,
                                               in_word_in_c, in_word_in_d}));
        end
      end
    end
    mismatches  <= err_cnt;
    blocks_due  <= expected_blocks.size();
    blocks_seen <= seen_cnt;
  end

endmodule

/* test/idea_block_cipher_test.sv */
// Top of the idea_block_cipher testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module idea_block_cipher_test;
  import idea_pkg::*;

  localparam int KEY_COUNT    = KEYS_PER_ROUND * 8 + OUT_KEYS;
  localparam int LIMIT        = 400000;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN        = 80;
  localparam int RANDOM_ITEMS = 1850;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_func;
  logic [IDX_W-1:0] in_subkey_index;
  word_t            in_subkey_value;
  word_t            in_word_in_a;
  word_t            in_word_in_b;
  word_t            in_word_in_c;
  word_t            in_word_in_d;
  logic             out_valid;
  logic             out_stall;
  word_t            out_word_out_a;
  word_t            out_word_out_b;
  word_t            out_word_out_c;
  word_t            out_word_out_d;

  int mismatches;
  int blocks_due;
  int blocks_seen;
  int send_idle;
  int recv_stall;
  int hold_left;
  logic hold_go;
  int cycles;
  int loads_sent;
  int blocks_sent;
  int dropped_loads;
  int idle_mix  [4] = '{0, 59, 0, 38};
  int stall_mix [4] = '{0, 0, 59, 38};

  idea_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_subkey_index(in_subkey_index), .in_subkey_value(in_subkey_value),
    .in_word_in_a(in_word_in_a), .in_word_in_b(in_word_in_b),
    .in_word_in_c(in_word_in_c), .in_word_in_d(in_word_in_d),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word_out_a(out_word_out_a), .out_word_out_b(out_word_out_b),
    .out_word_out_c(out_word_out_c), .out_word_out_d(out_word_out_d)
  );

  idea_block_cipher_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_subkey_index(in_subkey_index), .in_subkey_value(in_subkey_value),
    .in_word_in_a(in_word_in_a), .in_word_in_b(in_word_in_b),
    .in_word_in_c(in_word_in_c), .in_word_in_d(in_word_in_d),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word_out_a(out_word_out_a), .out_word_out_b(out_word_out_b),
    .out_word_out_c(out_word_out_c), .out_word_out_d(out_word_out_d),
    .mismatches(mismatches), .blocks_due(blocks_due), .blocks_seen(blocks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("idea_block_cipher: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off once hold_go is raised
  initial begin
    out_stall = 1'b0;
    hold_left = HOLD_OFF;
    forever begin
      @(negedge clk);
      if (hold_go && hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall);
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'h8000;
      default: return word_t'($urandom);
    endcase
  endfunction

  // returns right after the accepting edge
  task automatic send_beat(input func_t f, input logic [IDX_W-1:0] idx, input word_t kv,
                           input word_t a, input word_t b, input word_t c, input word_t d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_func         = f;
    in_subkey_index = idx;
    in_subkey_value = kv;
    in_word_in_a    = a;
    in_word_in_b    = b;
    in_word_in_c    = c;
    in_word_in_d    = d;
    do @(posedge clk); while (in_stall);
    if (f == FUNC_LOAD) begin
      loads_sent++;
      if (idx >= KEY_COUNT) dropped_loads++;
    end else begin
      blocks_sent++;
    end
  endtask

  task automatic random_item();
    logic [IDX_W-1:0] idx;
    if ($urandom_range(99) < 20) begin
      idx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(KEY_COUNT-1))
                                       : IDX_W'($urandom_range(63));
      send_beat(FUNC_LOAD, idx, rand_word(), word_t'($urandom), word_t'($urandom),
                word_t'($urandom), word_t'($urandom));
    end else begin
      send_beat(FUNC_BLOCK, IDX_W'($urandom), word_t'($urandom), rand_word(), rand_word(),
                rand_word(), rand_word());
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    hold_go         = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_LOAD;
    in_subkey_index = '0;
    in_subkey_value = '0;
    in_word_in_a    = '0;
    in_word_in_b    = '0;
    in_word_in_c    = '0;
    in_word_in_d    = '0;
    send_idle       = 0;
    recv_stall      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every subkey written before any block reads it
    for (int i = 0; i < KEY_COUNT; i++)
      send_beat(FUNC_LOAD, IDX_W'(i), word_t'($urandom), word_t'($urandom),
                word_t'($urandom), word_t'($urandom), word_t'($urandom));

    send_beat(FUNC_BLOCK, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(FUNC_BLOCK, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(FUNC_BLOCK, '0, '0, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE);
    send_beat(FUNC_BLOCK, 6'h3F, 16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    // zero keys in round one, all-ones keys in the output transform
    for (int i = 0; i < KEYS_PER_ROUND; i++)
      send_beat(FUNC_LOAD, IDX_W'(i), 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = KEY_COUNT - OUT_KEYS; i < KEY_COUNT; i++)
      send_beat(FUNC_LOAD, IDX_W'(i), 16'hFFFF, '0, '0, '0, '0);
    send_beat(FUNC_BLOCK, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(FUNC_BLOCK, '0, '0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    // loads past the store must leave it alone
    send_beat(FUNC_LOAD, IDX_W'(KEY_COUNT), 16'h0000, '0, '0, '0, '0);
    send_beat(FUNC_LOAD, 6'h3F, 16'hFFFF, '0, '0, '0, '0);
    send_beat(FUNC_BLOCK, '0, '0, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    send_beat(FUNC_LOAD, 6'd32, 16'h0001, '0, '0, '0, '0);
    send_beat(FUNC_BLOCK, 6'h2A, 16'h5555, 16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0);

    for (int p = 0; p < 4; p++) begin
      send_idle  = idle_mix[p];
      recv_stall = stall_mix[p];
      if (p == 0) hold_go = 1'b1;
      repeat (RANDOM_ITEMS / 4) random_item();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (blocks_due != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d blocks, %0d results compared, %0d subkey loads (%0d past the store)",
             blocks_sent, blocks_seen, loads_sent, dropped_loads);
    $display("traffic: no idling, sender idle, receiver stalls, both, and a %0d-cycle hold-off",
             HOLD_OFF);
    if (mismatches == 0 && blocks_due == 0)
      $display("idea_block_cipher: match");
    else
      $display("idea_block_cipher: mismatch");
    $finish;
  end

endmodule
